// ----- rtl/svpwm_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// svpwm_pkg
// shared types, widths and constants of the space vector pwm core
// ---------------------------------------------------------------------------
package svpwm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int NORM_W     = FRAC_BITS + 2;
    localparam int DUTY_W     = FRAC_BITS + 1;
    localparam int PROD_W     = NORM_W + 32;
    localparam int SUM_W      = NORM_W + 33;
    localparam int CNT_PROD_W = DUTY_W + 16;

    localparam logic [30:0] SQRT3_QUARTER_Q32 = 31'd1859775393;
    localparam logic [DUTY_W-1:0] DUTY_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [15:0] BUS_VOLTAGE_RST = 16'd7680;
    localparam logic [15:0] PWM_PERIOD_RST  = 16'd65535;

    localparam logic REG_BUS_VOLTAGE = 1'b0;
    localparam logic REG_PWM_PERIOD  = 1'b1;

    typedef struct packed {
        logic signed [15:0] volt_alpha;
        logic signed [15:0] volt_beta;
    } t_svpwm_in;

    typedef struct packed {
        logic [15:0] count_a;
        logic [15:0] count_b;
        logic [15:0] count_c;
        logic [2:0]  sector_num;
        logic        limited;
    } t_svpwm_out;

    // one active time: q32 dot product of the table entry with (a, b), clamped at zero
    function automatic logic [NORM_W-1:0] active_time(
        input logic [2:0]               idx,
        input logic signed [NORM_W-1:0] a,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [SUM_W-1:0] ax;
        logic signed [SUM_W-1:0] px;
        logic signed [SUM_W-1:0] ca;
        logic signed [SUM_W-1:0] cs;
        logic signed [SUM_W-1:0] s;
        ax = SUM_W'(a);
        px = SUM_W'(p);
        case (idx)
            3'd0: begin
                ca = ax <<< 31;
                cs = '0;
            end
            3'd1: begin
                ca = ax <<< 30;
                cs = px;
            end
            3'd2: begin
                ca = -(ax <<< 30);
                cs = px;
            end
            3'd3: begin
                ca = -(ax <<< 31);
                cs = '0;
            end
            3'd4: begin
                ca = -(ax <<< 30);
                cs = -px;
            end
            default: begin
                ca = ax <<< 30;
                cs = -px;
            end
        endcase
        s = ca + cs;
        active_time = s[SUM_W-1] ? '0 : s[32 +: NORM_W];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/space_vector_pwm_with_circle_limit_core.sv -----
// one request per cycle while the result is not stalled; the 32-stage root and two divider chains set the depth
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// synchronous active-low reset clears all valid bits and loads the register defaults
`default_nettype none
// ---------------------------------------------------------------------------
// space_vector_pwm_with_circle_limit_core
// circle limited space vector pwm, alpha/beta volts in, three compare counts out
// ---------------------------------------------------------------------------
module space_vector_pwm_with_circle_limit_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire svpwm_pkg::t_svpwm_in   i_in,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output svpwm_pkg::t_svpwm_out       o_out,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_idx,
    input  wire logic [15:0]            i_cfg_data
);
    import svpwm_pkg::*;

    typedef struct packed {
        logic signed [15:0] va;
        logic signed [15:0] vb;
        logic               lim;
    } t_sq_side;

    typedef struct packed {
        logic sign_a;
        logic sign_b;
        logic lim;
    } t_dn_side;

    typedef struct packed {
        logic [NORM_W-1:0] t1;
        logic [NORM_W-1:0] t2;
        logic              resc;
        logic [2:0]        sec;
        logic              lim;
    } t_rs_side;

    logic en;

    logic [15:0] r_bus;
    logic [15:0] r_period;

    // stage a/b/c: squares and limit test
    logic               r_a_vld, r_b_vld, r_c_vld;
    logic signed [15:0] r_a_va, r_a_vb, r_b_va, r_b_vb, r_c_va, r_c_vb;
    logic [31:0]        r_b_sqa, r_b_sqb, r_b_bussq;
    logic [32:0]        r_c_x3;
    logic               r_c_lim;
    logic [32:0]        mag;
    logic [32:0]        n_x3;

    // root pipeline side band
    logic [SQRT_STEPS-1:0] r_sq_vld;
    t_sq_side              r_sq_side [SQRT_STEPS];
    logic [31:0]           root;

    // stage d: divider setup
    logic        r_d_vld;
    logic [31:0] r_d_rem_a, r_d_rem_b, r_d_den;
    t_dn_side    r_d_side;
    t_sq_side    sq_out;
    logic [15:0] abs_a, abs_b;

    logic [DIV_STEPS-1:0] r_dn_vld;
    t_dn_side             r_dn_side [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_a, q_b;

    // stage e/f/g: sector, product, active times
    logic                     r_e_vld, r_f_vld, r_g_vld;
    logic signed [NORM_W-1:0] r_e_a, r_e_b, r_f_a;
    logic [2:0]               r_e_sec, r_f_sec, r_g_sec;
    logic                     r_e_lim, r_f_lim, r_g_lim;
    logic signed [PROD_W-1:0] r_f_p;
    logic [NORM_W-1:0]        r_g_t1, r_g_t2;
    logic signed [NORM_W-1:0] n_a, n_b;
    logic signed [NORM_W:0]   sum_ab, dif_ba;
    logic [2:0]               n_sec;
    logic [2:0]               s0, s1;

    // stage h and rescale pipeline
    logic              r_h_vld;
    logic [31:0]       r_h_rem1, r_h_rem2, r_h_den;
    logic              r_h_bit1, r_h_bit2;
    t_rs_side          r_h_side;
    logic [NORM_W:0]   tot;

    logic [DIV_STEPS-1:0] r_rs_vld;
    t_rs_side             r_rs_side [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_1, q_2;

    // stage i: duties
    logic              r_i_vld;
    logic [DUTY_W-1:0] r_i_da, r_i_db, r_i_dc;
    logic [2:0]        r_i_sec;
    logic              r_i_lim;
    t_rs_side          rs_out;
    logic [DUTY_W-1:0] t1f, t2f, t0, h;
    logic [DUTY_W-1:0] n_da, n_db, n_dc;

    // output stage
    logic                  r_out_vld;
    t_svpwm_out            r_out;
    logic [CNT_PROD_W-1:0] pa, pb, pc;

    assign en      = ~r_out_vld | i_ready;
    assign o_ready = en;
    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus    <= BUS_VOLTAGE_RST;
            r_period <= PWM_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BUS_VOLTAGE: r_bus    <= i_cfg_data;
                REG_PWM_PERIOD:  r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits of the whole pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_sq_vld  <= '0;
            r_d_vld   <= 1'b0;
            r_dn_vld  <= '0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_h_vld   <= 1'b0;
            r_rs_vld  <= '0;
            r_i_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld   <= i_valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_sq_vld  <= {r_sq_vld[SQRT_STEPS-2:0], r_c_vld};
            r_d_vld   <= r_sq_vld[SQRT_STEPS-1];
            r_dn_vld  <= {r_dn_vld[DIV_STEPS-2:0], r_d_vld};
            r_e_vld   <= r_dn_vld[DIV_STEPS-1];
            r_f_vld   <= r_e_vld;
            r_g_vld   <= r_f_vld;
            r_h_vld   <= r_g_vld;
            r_rs_vld  <= {r_rs_vld[DIV_STEPS-2:0], r_h_vld};
            r_i_vld   <= r_rs_vld[DIV_STEPS-1];
            r_out_vld <= r_i_vld;
        end
    end

    // limit test: 3*(va^2 + vb^2) against bus^2
    assign mag  = {1'b0, r_b_sqa} + {1'b0, r_b_sqb};
    assign n_x3 = {mag[31:0], 1'b0} + mag;

    svpwm_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_c_x3),
        .o_root (root)
    );

    assign sq_out = r_sq_side[SQRT_STEPS-1];
    assign abs_a  = sq_out.va[15] ? 16'(-sq_out.va) : 16'(sq_out.va);
    assign abs_b  = sq_out.vb[15] ? 16'(-sq_out.vb) : 16'(sq_out.vb);

    svpwm_div u_div_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem0 (r_d_rem_a),
        .i_bit0 (1'b0),
        .i_den  (r_d_den),
        .o_quot (q_a)
    );

    svpwm_div u_div_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem0 (r_d_rem_b),
        .i_bit0 (1'b0),
        .i_den  (r_d_den),
        .o_quot (q_b)
    );

    // signed normalized components and sector choice
    always_comb begin
        n_a = r_dn_side[DIV_STEPS-1].sign_a ? -NORM_W'({1'b0, q_a}) : NORM_W'({1'b0, q_a});
        n_b = r_dn_side[DIV_STEPS-1].sign_b ? -NORM_W'({1'b0, q_b}) : NORM_W'({1'b0, q_b});
        sum_ab = (NORM_W+1)'(n_a) + (NORM_W+1)'(n_b);
        dif_ba = (NORM_W+1)'(n_b) - (NORM_W+1)'(n_a);
        if (sum_ab < 0) begin
            if (dif_ba < 0) begin
                n_sec = 3'd5;
            end else if (n_b <= 0) begin
                n_sec = 3'd4;
            end else begin
                n_sec = 3'd3;
            end
        end else begin
            if (dif_ba >= 0) begin
                n_sec = 3'd2;
            end else if (n_b <= 0) begin
                n_sec = 3'd6;
            end else begin
                n_sec = 3'd1;
            end
        end
    end

    assign s0 = r_f_sec - 3'd1;
    assign s1 = (s0 == 3'd5) ? 3'd0 : s0 + 3'd1;

    assign tot = {1'b0, r_g_t1} + {1'b0, r_g_t2};

    svpwm_div u_div_t1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem0 (r_h_rem1),
        .i_bit0 (r_h_bit1),
        .i_den  (r_h_den),
        .o_quot (q_1)
    );

    svpwm_div u_div_t2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem0 (r_h_rem2),
        .i_bit0 (r_h_bit2),
        .i_den  (r_h_den),
        .o_quot (q_2)
    );

    // centred duties per sector
    always_comb begin
        rs_out = r_rs_side[DIV_STEPS-1];
        t1f = rs_out.resc ? q_1 : rs_out.t1[DUTY_W-1:0];
        t2f = rs_out.resc ? q_2 : rs_out.t2[DUTY_W-1:0];
        t0  = DUTY_ONE - t1f - t2f;
        h   = t0 >> 1;
        case (rs_out.sec)
            3'd1: begin
                n_da = h + t1f + t2f;
                n_db = h + t2f;
                n_dc = h;
            end
            3'd2: begin
                n_da = h + t1f;
                n_db = h + t1f + t2f;
                n_dc = h;
            end
            3'd3: begin
                n_da = h;
                n_db = h + t1f + t2f;
                n_dc = h + t2f;
            end
            3'd4: begin
                n_da = h;
                n_db = h + t1f;
                n_dc = h + t1f + t2f;
            end
            3'd5: begin
                n_da = h + t2f;
                n_db = h;
                n_dc = h + t1f + t2f;
            end
            default: begin
                n_da = h + t1f + t2f;
                n_db = h;
                n_dc = h + t1f;
            end
        endcase
    end

    assign pa = CNT_PROD_W'(r_i_da) * CNT_PROD_W'(r_period);
    assign pb = CNT_PROD_W'(r_i_db) * CNT_PROD_W'(r_period);
    assign pc = CNT_PROD_W'(r_i_dc) * CNT_PROD_W'(r_period);

    // data path registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_va <= i_in.volt_alpha;
            r_a_vb <= i_in.volt_beta;

            r_b_va    <= r_a_va;
            r_b_vb    <= r_a_vb;
            r_b_sqa   <= 32'(r_a_va * r_a_va);
            r_b_sqb   <= 32'(r_a_vb * r_a_vb);
            r_b_bussq <= 32'(r_bus) * 32'(r_bus);

            r_c_va  <= r_b_va;
            r_c_vb  <= r_b_vb;
            r_c_x3  <= n_x3;
            r_c_lim <= n_x3 > {1'b0, r_b_bussq};

            r_sq_side[0] <= '{va: r_c_va, vb: r_c_vb, lim: r_c_lim};
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end

            // unlimited: |v|*2^32 / (bus*2^15); zero bus leaves a zero vector
            r_d_rem_a <= {1'b0, abs_a, 15'd0};
            r_d_rem_b <= {1'b0, abs_b, 15'd0};
            if (sq_out.lim) begin
                r_d_den <= root;
            end else if (r_bus == 16'd0) begin
                r_d_den <= 32'd1;
            end else begin
                r_d_den <= {1'b0, r_bus, 15'd0};
            end
            r_d_side <= '{sign_a: sq_out.va[15], sign_b: sq_out.vb[15], lim: sq_out.lim};

            r_dn_side[0] <= r_d_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dn_side[k] <= r_dn_side[k-1];
            end

            r_e_a   <= n_a;
            r_e_b   <= n_b;
            r_e_sec <= n_sec;
            r_e_lim <= r_dn_side[DIV_STEPS-1].lim;

            r_f_a   <= r_e_a;
            r_f_p   <= PROD_W'($signed({1'b0, SQRT3_QUARTER_Q32}) * r_e_b);
            r_f_sec <= r_e_sec;
            r_f_lim <= r_e_lim;

            r_g_t1  <= active_time(s0, r_f_a, r_f_p);
            r_g_t2  <= active_time(s1, r_f_a, r_f_p);
            r_g_sec <= r_f_sec;
            r_g_lim <= r_f_lim;

            r_h_rem1 <= 32'(r_g_t1[NORM_W-1:1]);
            r_h_bit1 <= r_g_t1[0];
            r_h_rem2 <= 32'(r_g_t2[NORM_W-1:1]);
            r_h_bit2 <= r_g_t2[0];
            r_h_den  <= 32'(tot);
            r_h_side <= '{t1: r_g_t1, t2: r_g_t2, resc: tot > (NORM_W+1)'(DUTY_ONE),
                          sec: r_g_sec, lim: r_g_lim};

            r_rs_side[0] <= r_h_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_rs_side[k] <= r_rs_side[k-1];
            end

            r_i_da  <= n_da;
            r_i_db  <= n_db;
            r_i_dc  <= n_dc;
            r_i_sec <= rs_out.sec;
            r_i_lim <= rs_out.lim;

            r_out.count_a    <= pa[FRAC_BITS+15:FRAC_BITS];
            r_out.count_b    <= pb[FRAC_BITS+15:FRAC_BITS];
            r_out.count_c    <= pc[FRAC_BITS+15:FRAC_BITS];
            r_out.sector_num <= r_i_sec;
            r_out.limited    <= r_i_lim;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.sector_num != 3'd0 && o_out.sector_num != 3'd7))
        else $error("sector out of range");

    a_sector1_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.sector_num == 3'd1) |->
            (o_out.count_a >= o_out.count_b && o_out.count_b >= o_out.count_c))
        else $error("sector one counts out of order");

    a_duty_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i_vld |-> (r_i_da <= DUTY_ONE && r_i_db <= DUTY_ONE && r_i_dc <= DUTY_ONE))
        else $error("duty above one");

endmodule
`default_nettype wire

// ----- rtl/svpwm_sqrt.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// svpwm_sqrt
// pipelined integer square root of x * 2^30, one root bit per stage
// ---------------------------------------------------------------------------
module svpwm_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [32:0] i_x,
    output logic      [31:0] o_root
);
    import svpwm_pkg::*;

    logic [32:0] r_rem  [SQRT_STEPS];
    logic [31:0] r_root [SQRT_STEPS];
    logic [33:0] r_x    [SQRT_STEPS];
    logic [32:0] n_rem  [SQRT_STEPS];
    logic [31:0] n_root [SQRT_STEPS];
    logic [33:0] n_x    [SQRT_STEPS];

    genvar i;
    for (i = 0; i < SQRT_STEPS; i++) begin : g_step
        logic [32:0] rem_in;
        logic [31:0] root_in;
        logic [33:0] x_in;
        logic [1:0]  pair;
        logic [34:0] sh;
        logic [35:0] diff;
        logic        take;
        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = {1'b0, i_x};
        end else begin : g_next
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign x_in    = r_x[i-1];
        end
        // radicand bits below 30 are zero
        if (i <= 16) begin : g_bits
            assign pair = x_in[33-2*i -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end
        assign sh   = {rem_in, pair};
        assign diff = {1'b0, sh} - {2'b00, root_in, 2'b01};
        assign take = ~diff[35];
        assign n_rem[i]  = take ? diff[32:0] : sh[32:0];
        assign n_root[i] = {root_in[30:0], take};
        assign n_x[i]    = x_in;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_x[k]    <= n_x[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ----- rtl/svpwm_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// svpwm_div
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module svpwm_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [31:0]                     i_rem0,
    input  wire logic                            i_bit0,
    input  wire logic [31:0]                     i_den,
    output logic      [svpwm_pkg::DIV_STEPS-1:0] o_quot
);
    import svpwm_pkg::*;

    logic [31:0]          r_rem  [DIV_STEPS];
    logic [31:0]          r_den  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quot [DIV_STEPS];
    logic [31:0]          n_rem  [DIV_STEPS];
    logic [31:0]          n_den  [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_quot [DIV_STEPS];

    genvar j;
    for (j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [31:0]          rem_in;
        logic [31:0]          den_in;
        logic [DIV_STEPS-1:0] q_in;
        logic                 bit_in;
        logic [32:0]          sh;
        logic [32:0]          diff;
        logic                 take;
        if (j == 0) begin : g_first
            assign rem_in = i_rem0;
            assign den_in = i_den;
            assign q_in   = '0;
            assign bit_in = i_bit0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign q_in   = r_quot[j-1];
            assign bit_in = 1'b0;
        end
        // remainder stays below the divisor, so the borrow bit decides
        assign sh   = {rem_in, bit_in};
        assign diff = sh - {1'b0, den_in};
        assign take = ~diff[32];
        assign n_rem[j]  = take ? diff[31:0] : sh[31:0];
        assign n_den[j]  = den_in;
        assign n_quot[j] = {q_in[DIV_STEPS-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= n_den[k];
                r_quot[k] <= n_quot[k];
            end
        end
    end

    assign o_quot = r_quot[DIV_STEPS-1];

endmodule
`default_nettype wire
